// ===== src/re1c_pkg.sv =====
// Shared constants, request codes, sequencer states and structs for the order-1 rANS encoder.
`timescale 1ns / 1ps
`default_nettype none
package re1c_pkg;

    // Field and datapath widths
    localparam int STATE_W = 19;  // coder state
    localparam int PROB_W  = 12;  // frequency / cumulative
    localparam int WIDE_W  = 31;  // state before renormalization
    localparam int LOG_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int REQ_W   = 3;
    localparam int STEP_W  = 5;   // divide step counter

    localparam logic [LOG_W-1:0] MIN_TABLE_LOG   = 4'd5;
    localparam logic [LOG_W-1:0] RESET_TABLE_LOG = 4'd11;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WR_ORDER0 = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WR_ORDER1 = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET_EN    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ENCODE    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FLUSH     = 3'd4;

    // Result status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_ZERO_FREQ = 1'b1;

    // At most three bytes per item
    localparam logic [1:0] MAX_BYTES = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DIV,
        ST_COMBINE,
        ST_RENORM,
        ST_OUT_WAIT
    } fsm_t;

    // Table write / read request from the sequencer
    typedef struct packed {
        logic              o0_we;
        logic              o1_we;
        logic              en_we;
        logic              rd_en;
        logic [BYTE_W-1:0] sym;
        logic [BYTE_W-1:0] ctx;
        logic [PROB_W-1:0] freq;
        logic [PROB_W-1:0] cumul;
        logic              en;
    } tbl_req_t;

    // Selected table entry, valid the cycle after a read
    typedef struct packed {
        logic              ok;
        logic [PROB_W-1:0] freq;
        logic [PROB_W-1:0] cumul;
    } lookup_t;

endpackage
`default_nettype wire

// ===== src/re1c_tables.sv =====
// Order-0 and order-1 frequency tables plus the per-context enable flags.
`timescale 1ns / 1ps
`default_nettype none
module re1c_tables #(
    parameter int SYMBOLS = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire re1c_pkg::tbl_req_t req,
    output re1c_pkg::lookup_t       lookup
);

    localparam int SYM_W     = $clog2(SYMBOLS);
    localparam int O1_DEPTH  = 1 << (2 * SYM_W);
    localparam int ENTRY_W   = 2 * re1c_pkg::PROB_W;
    localparam int PW        = re1c_pkg::PROB_W;

    logic [ENTRY_W-1:0] o0_mem [SYMBOLS];
    logic [ENTRY_W-1:0] o1_mem [O1_DEPTH];
    logic [SYMBOLS-1:0] en_flags_reg;

    logic [ENTRY_W-1:0] o0_rd_reg;
    logic [ENTRY_W-1:0] o1_rd_reg;
    logic               en_rd_reg;
    logic               ok_rd_reg;

    logic               sym_ok;
    logic               ctx_ok;
    logic [SYM_W-1:0]   sym_idx;
    logic [SYM_W-1:0]   ctx_idx;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] sel_entry;

    // Range checks and indexes
    assign sym_ok   = ({1'b0, req.sym} < 9'(SYMBOLS));
    assign ctx_ok   = ({1'b0, req.ctx} < 9'(SYMBOLS));
    assign sym_idx  = req.sym[SYM_W-1:0];
    assign ctx_idx  = req.ctx[SYM_W-1:0];
    assign wr_entry = {req.freq, req.cumul};

    // Order-0 memory, registered read
    always_ff @(posedge clk)
    begin
        if (req.o0_we && sym_ok)
        begin
            o0_mem[sym_idx] <= wr_entry;
        end
        if (req.rd_en)
        begin
            o0_rd_reg <= o0_mem[sym_idx];
        end
    end

    // Order-1 memory, addressed by {context, symbol}
    always_ff @(posedge clk)
    begin
        if (req.o1_we && sym_ok && ctx_ok)
        begin
            o1_mem[{ctx_idx, sym_idx}] <= wr_entry;
        end
        if (req.rd_en)
        begin
            o1_rd_reg <= o1_mem[{ctx_idx, sym_idx}];
        end
    end

    // Context enable flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_flags_reg <= '0;
        end
        else if (req.en_we && ctx_ok)
        begin
            en_flags_reg[ctx_idx] <= req.en;
        end
    end

    // Flag and range result captured with the memory read
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            en_rd_reg <= en_flags_reg[ctx_idx];
            ok_rd_reg <= sym_ok && ctx_ok;
        end
    end

    // Pick the table for this context
    assign sel_entry     = en_rd_reg ? o1_rd_reg : o0_rd_reg;
    assign lookup.ok     = ok_rd_reg;
    assign lookup.freq   = sel_entry[ENTRY_W-1:PW];
    assign lookup.cumul  = sel_entry[PW-1:0];

endmodule
`default_nettype wire

// ===== src/re1c_div.sv =====
// Restoring divider: coder state by symbol frequency, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module re1c_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [re1c_pkg::STATE_W-1:0]  dividend,
    input  wire logic [re1c_pkg::PROB_W-1:0]   divisor,
    output logic                               done,
    output logic [re1c_pkg::STATE_W-1:0]       quotient,
    output logic [re1c_pkg::PROB_W-1:0]        remainder
);

    localparam int SW = re1c_pkg::STATE_W;
    localparam int PW = re1c_pkg::PROB_W;
    localparam int CW = re1c_pkg::STEP_W;
    localparam logic [CW-1:0] LAST_STEP = CW'(SW - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] quot_reg;
    logic [PW-1:0] rem_reg;
    logic [PW-1:0] dvs_reg;

    logic [PW+1:0] diff;
    logic          ge;

    // Trial subtract of the shifted partial remainder
    assign diff = {1'b0, rem_reg, quot_reg[SW-1]} - {2'b00, dvs_reg};
    assign ge   = !diff[PW+1];

    // Step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shift register holds dividend bits, then quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[SW-2:0], ge};
            rem_reg  <= ge ? diff[PW-1:0] : {rem_reg[PW-2:0], quot_reg[SW-1]};
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ===== src/rans_encoder_order1_context.sv =====
// rANS encoder with order-1 context: table loading, sequencer and state datapath.
//
// Usage: one input channel (in_valid / in_stall) carries requests: table entry
// writes for the order-0 table, the order-1 table of a context, a context
// enable flag, an encode of one symbol (fed in reverse order), or a flush.
// Results leave on the output channel (out_valid / out_stall), one byte per
// transfer, with last set on the final result of a request and status set on
// a zero-frequency or out-of-range error. table_log is written through cfg_wr_en/cfg_wr_data;
// the user writes it only while the block is idle; the block does not enforce it.
// Sequence: table writes produce nothing. An encode walks a registered table
// lookup, a 19-step bit-serial divide and a combine step, then renormalization
// emits its bytes one at a time, and the block returns to idle after the last
// byte leaves. A flush goes straight to renormalization of the coder state.
// in_stall is high from the accepted encode or flush until it is finished.
// If the receiver stalls, the result is held in the output register and the
// sequencer waits. Reset sets table_log to 11, the coder state to M and all
// context enables to zero; table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module rans_encoder_order1_context #(
    parameter int SYMBOLS       = 256,
    parameter int MAX_TABLE_LOG = 11
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  req_type,
    input  wire logic [7:0]  symbol,
    input  wire logic [7:0]  context_req,
    input  wire logic [11:0] freq_value,
    input  wire logic [11:0] cumul_value,
    input  wire logic        enable_bit,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             status,
    output logic             last
);

    localparam int SW = re1c_pkg::STATE_W;
    localparam int PW = re1c_pkg::PROB_W;
    localparam int WW = re1c_pkg::WIDE_W;
    localparam int LW = re1c_pkg::LOG_W;
    localparam int BW = re1c_pkg::BYTE_W;
    localparam logic [LW-1:0] MAX_LOG   = LW'(MAX_TABLE_LOG);
    localparam logic [LW-1:0] RESET_LOG = (re1c_pkg::RESET_TABLE_LOG > MAX_LOG) ?
                                          MAX_LOG : re1c_pkg::RESET_TABLE_LOG;
    localparam logic [SW-1:0] RESET_STATE = SW'(1) << RESET_LOG;

    re1c_pkg::fsm_t     state_reg, state_next;
    re1c_pkg::tbl_req_t tbl_req;
    re1c_pkg::lookup_t  lookup;

    logic [LW-1:0] table_log_reg;
    logic [SW-1:0] coder_state_reg;
    logic          err_reg;
    logic          flush_reg;
    logic [1:0]    cnt_reg;
    logic [WW-1:0] x_reg;
    logic [PW-1:0] c_reg;
    logic          out_valid_reg;
    logic [BW-1:0] out_byte_reg;
    logic          status_reg;
    logic          last_reg;

    logic          in_accept;
    logic          out_accept;
    logic          is_encode;
    logic          is_flush;
    logic          lookup_good;
    logic [LW-1:0] eff_log;
    logic [SW-1:0] m_val;
    logic [WW-1:0] thr;
    logic [WW-1:0] x_shift;
    logic [WW-1:0] combine_sum;
    logic          emit_now;
    logic          emit_after;

    logic          div_start;
    logic          div_done;
    logic [SW-1:0] div_quot;
    logic [PW-1:0] div_rem;

    logic          ld_flush;
    logic          ld_err;
    logic          ld_combine;
    logic          ld_emit;
    logic          commit;

    // Handshakes
    assign in_stall   = (state_reg != re1c_pkg::ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign is_encode  = (req_type == re1c_pkg::REQ_ENCODE);
    assign is_flush   = (req_type == re1c_pkg::REQ_FLUSH);

    // Table requests go straight to the tables on transfer
    always_comb
    begin
        tbl_req.o0_we = in_accept && (req_type == re1c_pkg::REQ_WR_ORDER0);
        tbl_req.o1_we = in_accept && (req_type == re1c_pkg::REQ_WR_ORDER1);
        tbl_req.en_we = in_accept && (req_type == re1c_pkg::REQ_SET_EN);
        tbl_req.rd_en = in_accept && is_encode;
        tbl_req.sym   = symbol;
        tbl_req.ctx   = context_req;
        tbl_req.freq  = freq_value;
        tbl_req.cumul = cumul_value;
        tbl_req.en    = enable_bit;
    end

    re1c_tables #(
        .SYMBOLS (SYMBOLS)
    ) u_tables (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (tbl_req),
        .lookup (lookup)
    );

    re1c_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (coder_state_reg),
        .divisor   (lookup.freq),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Effective table log, clamped to the supported range
    always_comb
    begin
        if (table_log_reg < re1c_pkg::MIN_TABLE_LOG)
        begin
            eff_log = re1c_pkg::MIN_TABLE_LOG;
        end
        else if (table_log_reg > MAX_LOG)
        begin
            eff_log = MAX_LOG;
        end
        else
        begin
            eff_log = table_log_reg;
        end
    end

    assign m_val   = SW'(1) << eff_log;
    assign thr     = WW'(1) << (5'(eff_log) + 5'd8);
    assign x_shift = x_reg >> BW;

    // x = (x / f) * M + c + x % f
    assign combine_sum = (WW'(div_quot) << eff_log) + WW'(c_reg) + WW'(div_rem);

    // Renormalization tests: now and after this byte
    assign emit_now   = (cnt_reg != re1c_pkg::MAX_BYTES) &&
                        (flush_reg ? (x_reg != '0) : (x_reg >= thr));
    assign emit_after = (cnt_reg != 2'd2) &&
                        (flush_reg ? (x_shift != '0) : (x_shift >= thr));

    assign lookup_good = lookup.ok && (lookup.freq != '0);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            re1c_pkg::ST_IDLE:
            begin
                if (in_accept && is_encode)
                begin
                    state_next = re1c_pkg::ST_LOOKUP;
                end
                else if (in_accept && is_flush)
                begin
                    state_next = re1c_pkg::ST_RENORM;
                end
            end
            re1c_pkg::ST_LOOKUP:
            begin
                state_next = lookup_good ? re1c_pkg::ST_DIV : re1c_pkg::ST_OUT_WAIT;
            end
            re1c_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = re1c_pkg::ST_COMBINE;
                end
            end
            re1c_pkg::ST_COMBINE:
            begin
                state_next = re1c_pkg::ST_RENORM;
            end
            re1c_pkg::ST_RENORM:
            begin
                if (!err_reg && emit_now)
                begin
                    state_next = re1c_pkg::ST_OUT_WAIT;
                end
                else
                begin
                    state_next = re1c_pkg::ST_IDLE;
                end
            end
            re1c_pkg::ST_OUT_WAIT:
            begin
                if (out_accept)
                begin
                    state_next = re1c_pkg::ST_RENORM;
                end
            end
            default:
            begin
                state_next = re1c_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer strobes
    always_comb
    begin
        ld_flush   = 1'b0;
        div_start  = 1'b0;
        ld_err     = 1'b0;
        ld_combine = 1'b0;
        ld_emit    = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            re1c_pkg::ST_IDLE:
            begin
                ld_flush = in_accept && is_flush;
            end
            re1c_pkg::ST_LOOKUP:
            begin
                div_start = lookup_good;
                ld_err    = !lookup_good;
            end
            re1c_pkg::ST_COMBINE:
            begin
                ld_combine = 1'b1;
            end
            re1c_pkg::ST_RENORM:
            begin
                ld_emit = !err_reg && emit_now;
                commit  = !err_reg && !emit_now;
            end
            re1c_pkg::ST_DIV, re1c_pkg::ST_OUT_WAIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= re1c_pkg::ST_IDLE;
            table_log_reg   <= re1c_pkg::RESET_TABLE_LOG;
            coder_state_reg <= RESET_STATE;
            err_reg         <= 1'b0;
            flush_reg       <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                table_log_reg <= cfg_wr_data;
            end
            if (commit)
            begin
                coder_state_reg <= flush_reg ? m_val : x_reg[SW-1:0];
            end
            if (ld_flush || div_start)
            begin
                err_reg   <= 1'b0;
                flush_reg <= ld_flush;
            end
            else if (ld_err)
            begin
                err_reg <= 1'b1;
            end
            if (ld_flush || ld_combine)
            begin
                cnt_reg <= '0;
            end
            else if (ld_emit)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            if (ld_emit || ld_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath and output payload
    always_ff @(posedge clk)
    begin
        if (ld_flush)
        begin
            x_reg <= WW'(coder_state_reg);
        end
        else if (ld_combine)
        begin
            x_reg <= combine_sum;
        end
        else if (ld_emit)
        begin
            x_reg <= x_shift;
        end
        if (div_start)
        begin
            c_reg <= lookup.cumul;
        end
        if (ld_emit)
        begin
            out_byte_reg <= x_reg[BW-1:0];
            status_reg   <= re1c_pkg::STATUS_OK;
            last_reg     <= !emit_after;
        end
        else if (ld_err)
        begin
            out_byte_reg <= '0;
            status_reg   <= re1c_pkg::STATUS_ZERO_FREQ;
            last_reg     <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

// ===== src/re1c_checker.sv =====
// Port-level checks for the order-1 rANS encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module re1c_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic [2:0] req_type,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       status,
    input wire logic       last
);

    // A pending result keeps the input side closed
    a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

    // An error result is always single and carries a zero byte
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (last && (out_byte == 8'd0)))
        else $error("error result not last or byte not zero");

    // An encode or flush transfer leaves the block busy, with in_stall raised
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall &&
         (req_type == re1c_pkg::REQ_ENCODE || req_type == re1c_pkg::REQ_FLUSH))
        |=> in_stall)
        else $error("not busy after encode or flush transfer");

    // Nothing follows the last result of a request back to back
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> !out_valid)
        else $error("result right after last transfer");

    // Table writes never stall the block
    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall &&
         (req_type == re1c_pkg::REQ_WR_ORDER0 || req_type == re1c_pkg::REQ_WR_ORDER1 ||
          req_type == re1c_pkg::REQ_SET_EN))
        |=> !in_stall)
        else $error("busy after table write");

endmodule

bind rans_encoder_order1_context re1c_checker u_re1c_checker (.*);
`default_nettype wire
